// File: sv/circular_deque_macros.svh
// Assertion macros used by the circular deque controller.
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH
`ifndef SYNTH
// Condition that must hold at every clock edge out of reset.
`define CDQ_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("circular_deque: invariant violated");
// Condition in one cycle implies a consequence in the next cycle.
`define CDQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("circular_deque: sequencing violated");
`else
`define CDQ_ASSERT_ALWAYS(label, cond)
`define CDQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: sv/cdq_pkg.sv
// Package: sizes, command and status codes and types of the circular deque.
`default_nettype none
package cdq_pkg;

  // Ring depth and the widths that follow from it
  localparam int DEPTH  = 8;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  // Command codes
  localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
  localparam logic [1:0] CMD_PUSH_BACK  = 2'd1;
  localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
  localparam logic [1:0] CMD_POP_BACK   = 2'd3;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // Request from the controller to the ring memory
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage
`default_nettype wire

// File: sv/cdq_if.sv
// Channel interfaces: command channel and result channel.
`default_nettype none
interface cdq_in_if import cdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               cmd;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output cmd, output push_value, input ready);
  modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface cdq_out_if import cdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] pop_value;
  logic [1:0]               status;
  logic [3:0]               fill_level;

  modport source (output valid, output pop_value, output status, output fill_level,
                  input ready);
  modport sink   (input valid, input pop_value, input status, input fill_level,
                  output ready);
endinterface
`default_nettype wire

// File: sv/cdq_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered output
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: sv/cdq_ctrl.sv
// Deque controller: head/tail/count registers, command decode and result register.
`default_nettype none
`include "circular_deque_macros.svh"
module cdq_ctrl import cdq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  cdq_in_if.sink           in_ch,
  cdq_out_if.source        out_ch,
  output ram_req_t         ram_req,
  input  wire logic [DATA_W-1:0] rd_data
);

  localparam logic       ST_IDLE = 1'b0;
  localparam logic       ST_PEND = 1'b1;
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(DEPTH);

  logic              state_r, state_nxt;
  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [ADDR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [3:0]        out_fill_r, out_fill_nxt;

  logic              accept;
  logic              full;
  logic              empty;
  logic [ADDR_W-1:0] head_up, head_dn, tail_up, tail_dn;

  // Ready only when no pop read is outstanding and the result slot frees up
  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  assign full  = (count_r == FULL_CNT);
  assign empty = (count_r == '0);

  // Circular pointer steps
  assign head_up = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
  assign head_dn = (head_r == '0) ? LAST_IDX : head_r - 1'b1;
  assign tail_up = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
  assign tail_dn = (tail_r == '0) ? LAST_IDX : tail_r - 1'b1;

  // Command decode and next state
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_fill_nxt   = out_fill_r;
    ram_req.we     = 1'b0;
    ram_req.waddr  = tail_r;
    ram_req.wdata  = in_ch.push_value;
    ram_req.re     = 1'b0;
    ram_req.raddr  = head_r;

    if (state_r == ST_PEND) begin
      // read data is back: pointers and count already moved
      out_valid_nxt  = 1'b1;
      out_value_nxt  = rd_data;
      out_status_nxt = STAT_OK;
      out_fill_nxt   = 4'(count_r);
      state_nxt      = ST_IDLE;
    end else if (accept) begin
      out_value_nxt  = '0;
      out_status_nxt = STAT_OK;
      unique case (in_ch.cmd)
        CMD_PUSH_FRONT: begin
          if (full) begin
            out_status_nxt = STAT_FULL;
          end else begin
            ram_req.we    = 1'b1;
            ram_req.waddr = head_dn;
            head_nxt      = head_dn;
            count_nxt     = count_r + 1'b1;
          end
        end
        CMD_PUSH_BACK: begin
          if (full) begin
            out_status_nxt = STAT_FULL;
          end else begin
            ram_req.we    = 1'b1;
            ram_req.waddr = tail_r;
            tail_nxt      = tail_up;
            count_nxt     = count_r + 1'b1;
          end
        end
        CMD_POP_FRONT: begin
          if (empty) begin
            out_status_nxt = STAT_EMPTY;
          end else begin
            ram_req.re    = 1'b1;
            ram_req.raddr = head_r;
            head_nxt      = head_up;
            count_nxt     = count_r - 1'b1;
          end
        end
        CMD_POP_BACK: begin
          if (empty) begin
            out_status_nxt = STAT_EMPTY;
          end else begin
            ram_req.re    = 1'b1;
            ram_req.raddr = tail_dn;
            tail_nxt      = tail_dn;
            count_nxt     = count_r - 1'b1;
          end
        end
        default: begin
          out_status_nxt = STAT_OK;
        end
      endcase
      out_fill_nxt = 4'(count_nxt);
      if (ram_req.re) begin
        // result follows when the read data returns
        state_nxt     = ST_PEND;
        out_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pop_value  = out_value_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.fill_level = out_fill_r;

  // Checks
  `CDQ_ASSERT_ALWAYS(a_count_bound, count_r <= FULL_CNT)
  `CDQ_ASSERT_ALWAYS(a_one_access, !(ram_req.we && ram_req.re))
  `CDQ_ASSERT_NEXT(a_read_pends, ram_req.re, state_r == ST_PEND && !out_valid_r)
  `CDQ_ASSERT_NEXT(a_pend_delivers, state_r == ST_PEND, state_r == ST_IDLE && out_valid_r)

endmodule
`default_nettype wire

// File: sv/circular_deque.sv
// Top level of the circular deque: controller plus ring memory.
//
// Usage:
//   in_ch  carries one command per transaction: cmd (push front, push back,
//          pop front, pop back) and push_value, used by pushes only.
//   out_ch returns exactly one result per command: pop_value (zero unless a
//          pop succeeded), status (ok, full, empty) and fill_level after it.
//   A transaction completes on a rising clk edge with valid and ready high.
// Result timing: a push or a refused command has its result valid in the cycle
//   after acceptance; a successful pop passes through the ring memory read
//   register and the pending state before the data reaches the result register.
// Throughput: one push per cycle while the receiver takes every result; after
//   a successful pop, no new command is taken while its memory read is pending.
// Reset (rst_n low, synchronous): head, tail and count go to zero and the
//   result register empties; the ring contents are left as they are.
// Receiver stall: the result is held in the output register; a new command
//   is taken in the same cycle the pending result is taken, not earlier.
`default_nettype none
module circular_deque import cdq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  cdq_in_if.sink    in_ch,
  cdq_out_if.source out_ch
);

  ram_req_t          ram_req;
  logic [DATA_W-1:0] rd_data;

  cdq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .ram_req (ram_req),
    .rd_data (rd_data)
  );

  cdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rd_data)
  );

endmodule
`default_nettype wire
